// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL, included by command_id_allocator.
// Each macro takes a label, a clock, a reset, a trigger and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence holds in the same cycle as the trigger.
`define ASSERT_SAME(lbl, clk, rst, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// Consequence holds in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

// ----- rtl/cia_pkg.sv -----
// ----------------------------------------------------------------------------
// cia_pkg
// Types and constants of the command id allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cia_pkg;

  // Number of command ids and derived widths
  localparam int CAPACITY = 64;
  localparam int ID_W     = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Request codes
  typedef enum logic [1:0] {
    MODE_RELEASE  = 2'd0,
    MODE_ALLOC    = 2'd1,
    MODE_COMPLETE = 2'd2,
    MODE_QUERY    = 2'd3
  } cia_mode_t;

  // Per-id status codes
  typedef enum logic [1:0] {
    ST_FREE      = 2'd0,
    ST_PENDING   = 2'd1,
    ST_COMPLETED = 2'd2
  } cia_status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC
  } cia_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic lookup;
    logic execute;
  } cia_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } cia_stat_t;

endpackage

`default_nettype wire

// ----- rtl/cia_if.sv -----
// ----------------------------------------------------------------------------
// cia_if
// Request and response channels of the command id allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cia_req_if import cia_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      mode;
  logic [ID_W-1:0] id;

  modport source (output valid, output mode, output id, input ready);
  modport sink   (input valid, input mode, input id, output ready);
endinterface

interface cia_rsp_if import cia_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  result_id;
  logic             failed;
  logic             applied;
  logic [1:0]       id_status;
  logic [CNT_W-1:0] pending_count;
  logic [CNT_W-1:0] completed_count;

  modport source (output valid, output result_id, output failed, output applied,
                  output id_status, output pending_count, output completed_count,
                  input ready);
  modport sink   (input valid, input result_id, input failed, input applied,
                  input id_status, input pending_count, input completed_count,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/cia_ctrl.sv -----
// ----------------------------------------------------------------------------
// cia_ctrl
// Sequencer: capture a request, look up the id status, then execute.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_ctrl import cia_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire cia_stat_t stat,
  output cia_cmd_t       cmd
);

  cia_state_t state;
  cia_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register can take the result
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/cia_dp.sv -----
// ----------------------------------------------------------------------------
// cia_dp
// Free ring, status table, counters and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_dp import cia_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cia_cmd_t         cmd,
  output cia_stat_t             stat,
  input  wire logic [1:0]       req_mode,
  input  wire logic [ID_W-1:0]  req_id,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [ID_W-1:0]       out_result_id,
  output logic                  out_failed,
  output logic                  out_applied,
  output logic [1:0]            out_id_status,
  output logic [CNT_W-1:0]      out_pending_count,
  output logic [CNT_W-1:0]      out_completed_count
);

  // Free ring memory; an entry never written holds its own index
  logic [ID_W-1:0]     ring_mem [CAPACITY];
  logic [CAPACITY-1:0] ring_valid;
  // Status table memory; an entry never written reads free
  logic [1:0]          state_mem [CAPACITY];
  logic [CAPACITY-1:0] state_valid;

  logic [ID_W-1:0]  ring_head;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] pending_total;
  logic [CNT_W-1:0] completed_total;

  // Request and lookup registers
  cia_mode_t       mode_q;
  logic [ID_W-1:0] id_q;
  logic [ID_W-1:0] ring_raw;
  logic            ring_hit;
  logic [ID_W-1:0] head_q;
  logic [1:0]      st_raw;
  logic            st_hit;
  logic [ID_W-1:0] addr_q;

  logic [ID_W-1:0]  popped;
  logic [ID_W-1:0]  lookup_addr;
  cia_status_t      cur_status;
  logic [CNT_W-1:0] tail_sum;
  logic [ID_W-1:0]  tail;
  logic [ID_W-1:0]  head_inc;

  // Execute results
  logic             st_we;
  cia_status_t      st_wdata;
  logic             ring_we;
  logic             head_adv;
  logic [CNT_W-1:0] free_count_next;
  logic [CNT_W-1:0] pending_next;
  logic [CNT_W-1:0] completed_next;
  logic [ID_W-1:0]  res_id;
  logic             res_failed;
  logic             res_applied;
  cia_status_t      res_status;

  assign stat.out_free = !out_valid || out_ready;

  assign popped      = ring_hit ? ring_raw : head_q;
  assign lookup_addr = (mode_q == MODE_ALLOC) ? popped : id_q;
  assign cur_status  = st_hit ? cia_status_t'(st_raw) : ST_FREE;

  // Ring tail and head wrap modulo the capacity
  assign tail_sum = CNT_W'(ring_head) + free_count;
  assign tail     = (tail_sum >= CNT_W'(CAPACITY)) ? ID_W'(tail_sum - CNT_W'(CAPACITY))
                                                   : ID_W'(tail_sum);
  assign head_inc = (ring_head == ID_W'(CAPACITY - 1)) ? '0 : ring_head + 1'b1;

  // Capture request and read the ring head
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= cia_mode_t'(req_mode);
      id_q     <= req_id;
      ring_raw <= ring_mem[ring_head];
      ring_hit <= ring_valid[ring_head];
      head_q   <= ring_head;
    end
  end

  // Read the status of the addressed id
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      st_raw <= state_mem[lookup_addr];
      st_hit <= state_valid[lookup_addr];
      addr_q <= lookup_addr;
    end
  end

  // Decide the transition
  always_comb begin
    st_we           = 1'b0;
    st_wdata        = ST_FREE;
    ring_we         = 1'b0;
    head_adv        = 1'b0;
    free_count_next = free_count;
    pending_next    = pending_total;
    completed_next  = completed_total;
    res_id          = id_q;
    res_failed      = 1'b0;
    res_applied     = 1'b0;
    res_status      = cur_status;
    case (mode_q)
      MODE_ALLOC: begin
        if (free_count == '0) begin
          // empty ring: fixed failure result
          res_failed = 1'b1;
          res_id     = '0;
          res_status = ST_FREE;
        end else begin
          head_adv        = 1'b1;
          free_count_next = free_count - 1'b1;
          res_id          = addr_q;
          if (cur_status == ST_FREE) begin
            st_we        = 1'b1;
            st_wdata     = ST_PENDING;
            pending_next = pending_total + 1'b1;
            res_applied  = 1'b1;
            res_status   = ST_PENDING;
          end else begin
            // popped id still in use: consume it and report failure
            res_failed = 1'b1;
          end
        end
      end
      MODE_COMPLETE: begin
        if (cur_status == ST_PENDING) begin
          st_we    = 1'b1;
          st_wdata = ST_COMPLETED;
          if (pending_total != '0) begin
            pending_next = pending_total - 1'b1;
          end
          completed_next = completed_total + 1'b1;
          res_applied    = 1'b1;
          res_status     = ST_COMPLETED;
        end
      end
      MODE_RELEASE: begin
        if (cur_status == ST_COMPLETED) begin
          st_we    = 1'b1;
          st_wdata = ST_FREE;
          // drop the push when the ring is already full
          if (free_count < CNT_W'(CAPACITY)) begin
            ring_we         = 1'b1;
            free_count_next = free_count + 1'b1;
          end
          if (completed_total != '0) begin
            completed_next = completed_total - 1'b1;
          end
          res_applied = 1'b1;
          res_status  = ST_FREE;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (cmd.execute && st_we) begin
      state_mem[addr_q] <= st_wdata;
    end
    if (cmd.execute && ring_we) begin
      ring_mem[tail] <= id_q;
    end
  end

  // Valid bits, ring pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid      <= '0;
      state_valid     <= '0;
      ring_head       <= '0;
      free_count      <= CNT_W'(CAPACITY);
      pending_total   <= '0;
      completed_total <= '0;
    end else if (cmd.execute) begin
      if (st_we) begin
        state_valid[addr_q] <= 1'b1;
      end
      if (ring_we) begin
        ring_valid[tail] <= 1'b1;
      end
      if (head_adv) begin
        ring_head <= head_inc;
      end
      free_count      <= free_count_next;
      pending_total   <= pending_next;
      completed_total <= completed_next;
    end
  end

  // Result register: load on execute, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_result_id       <= res_id;
      out_failed          <= res_failed;
      out_applied         <= res_applied;
      out_id_status       <= res_status;
      out_pending_count   <= pending_next;
      out_completed_count <= completed_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/command_id_allocator.sv -----
// ----------------------------------------------------------------------------
// command_id_allocator
// Free-list allocator of command ids with a per-id status table.
// ----------------------------------------------------------------------------
// A request goes from transfer to a loaded result through capture (latch it
// and read the head of the free ring), lookup (read the status table entry,
// for allocate at the id just read from the ring) and execute (apply the
// transition and load the result register, held while it has an untaken
// result). The reads are dependent; a new request is taken once the previous
// one has loaded its result, even while that result still waits to be taken.
// Both memories come out of reset at once through per-entry valid bits, so
// there is no clearing pass. Response counts are the totals after the request.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module command_id_allocator import cia_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  cia_req_if.sink   req,
  cia_rsp_if.source rsp
);

  cia_cmd_t  cmd;
  cia_stat_t stat;

  cia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cia_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .req_mode            (req.mode),
    .req_id              (req.id),
    .out_ready           (rsp.ready),
    .out_valid           (rsp.valid),
    .out_result_id       (rsp.result_id),
    .out_failed          (rsp.failed),
    .out_applied         (rsp.applied),
    .out_id_status       (rsp.id_status),
    .out_pending_count   (rsp.pending_count),
    .out_completed_count (rsp.completed_count)
  );

  // Checks
  `ASSERT_NEXT(a_busy_after_transfer, clk, rst, req.valid && req.ready, !req.ready)
  `ASSERT_SAME(a_exec_needs_room, clk, rst, cmd.execute, !rsp.valid || rsp.ready)
  `ASSERT_SAME(a_not_failed_and_applied, clk, rst, rsp.valid, !(rsp.failed && rsp.applied))
  `ASSERT_SAME(a_counts_bounded, clk, rst, rsp.valid,
               ({1'b0, rsp.pending_count} + {1'b0, rsp.completed_count}) <= (CNT_W + 1)'(CAPACITY))

endmodule

`default_nettype wire

// ----- sim/cia_tag_checker.sv -----
// ----------------------------------------------------------------------------
// cia_tag_checker
// Watches both channels of the command id allocator, predicts every result
// from its own copy of the free ring and status table, and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cia_tag_checker import cia_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cia_req_if          req,
  cia_rsp_if          rsp,
  output int unsigned errors,
  output int unsigned expected_left,
  output int unsigned n_checked,
  output int unsigned n_granted,
  output int unsigned n_empty,
  output int unsigned n_completed,
  output int unsigned n_released,
  output int unsigned n_ignored
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ID_W-1:0]  result_id;
    logic             failed;
    logic             applied;
    logic [1:0]       id_status;
    logic [CNT_W-1:0] pending_count;
    logic [CNT_W-1:0] completed_count;
  } outcome_t;

  // Shadow of the allocator state
  logic [ID_W-1:0] free_ring [CAPACITY];
  cia_status_t     id_table  [CAPACITY];
  int unsigned     ring_head;
  int unsigned     free_n;
  int unsigned     pending_n;
  int unsigned     completed_n;

  outcome_t outcome_q [$];

  function automatic void clear_shadow();
    for (int k = 0; k < CAPACITY; k++) begin
      free_ring[k] = ID_W'(k);
      id_table[k]  = ST_FREE;
    end
    ring_head   = 0;
    free_n      = CAPACITY;
    pending_n   = 0;
    completed_n = 0;
  endfunction

  // Apply one request to the shadow state and return the result it yields
  function automatic outcome_t predict_outcome(input cia_mode_t mode,
                                               input logic [ID_W-1:0] id);
    outcome_t    o;
    logic        empty_alloc;
    logic [ID_W-1:0] popped;
    int unsigned tail;
    o             = '0;
    o.result_id   = id;
    empty_alloc   = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        if (free_n == 0) begin
          // nothing left on the ring: fixed result, no state change
          o.failed    = 1'b1;
          o.result_id = '0;
          empty_alloc = 1'b1;
        end else begin
          popped      = free_ring[ring_head];
          ring_head   = (ring_head + 1) % CAPACITY;
          free_n--;
          o.result_id = popped;
          if (id_table[popped] == ST_FREE) begin
            id_table[popped] = ST_PENDING;
            pending_n++;
            o.applied = 1'b1;
          end else begin
            // popped id still in use: consume it and report failure
            o.failed = 1'b1;
          end
        end
      end
      MODE_COMPLETE: begin
        if (id_table[id] == ST_PENDING) begin
          id_table[id] = ST_COMPLETED;
          if (pending_n > 0) pending_n--;
          completed_n++;
          o.applied = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (id_table[id] == ST_COMPLETED) begin
          id_table[id] = ST_FREE;
          // push at the tail unless the ring is already full
          if (free_n < CAPACITY) begin
            tail            = (ring_head + free_n) % CAPACITY;
            free_ring[tail] = id;
            free_n++;
          end
          if (completed_n > 0) completed_n--;
          o.applied = 1'b1;
        end
      end
      default: ;
    endcase
    o.id_status       = empty_alloc ? ST_FREE : id_table[o.result_id];
    o.pending_count   = CNT_W'(pending_n);
    o.completed_count = CNT_W'(completed_n);
    return o;
  endfunction

  function automatic string describe(input outcome_t o);
    return $sformatf("id %0d failed %0d applied %0d status %0d pending %0d completed %0d",
                     o.result_id, o.failed, o.applied, o.id_status,
                     o.pending_count, o.completed_count);
  endfunction

  // Compare each response transfer, then predict each request transfer
  always @(posedge clk) begin
    outcome_t  want;
    outcome_t  got;
    cia_mode_t mode;
    if (rst) begin
      clear_shadow();
      outcome_q.delete();
      errors      = 0;
      n_checked   = 0;
      n_granted   = 0;
      n_empty     = 0;
      n_completed = 0;
      n_released  = 0;
      n_ignored   = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.result_id       = rsp.result_id;
        got.failed          = rsp.failed;
        got.applied         = rsp.applied;
        got.id_status       = rsp.id_status;
        got.pending_count   = rsp.pending_count;
        got.completed_count = rsp.completed_count;
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("[%0t] unexpected result: %s", $realtime, describe(got));
        end else begin
          want = outcome_q.pop_front();
          n_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("[%0t] mismatch on result %0d", $realtime, n_checked);
              $display("    expected %s", describe(want));
              $display("    actual   %s", describe(got));
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        mode = cia_mode_t'(req.mode);
        if (mode == MODE_ALLOC && free_n == 0) n_empty++;
        want = predict_outcome(mode, req.id);
        outcome_q.push_back(want);
        case (mode)
          MODE_ALLOC:    if (want.applied) n_granted++;
          MODE_COMPLETE: if (want.applied) n_completed++; else n_ignored++;
          MODE_RELEASE:  if (want.applied) n_released++; else n_ignored++;
          default: ;
        endcase
      end
    end
    expected_left = outcome_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the command id allocator.
// ----------------------------------------------------------------------------
// A short directed sequence walks every status transition, then a burst of
// allocations drains the free ring past empty. Random episodes follow, each
// leaning toward filling, draining, a mix, or plain noise, with ids for
// complete and release mostly taken from ids seen pending or completed.
// Both sides insert random idle cycles; some episodes run without gaps.
`timescale 1ns / 1ps

module testbench;
  import cia_pkg::*;

  localparam int TOTAL_ITEMS  = 1400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 500000;

  typedef enum int {
    EP_FILL,
    EP_DRAIN,
    EP_MIXED,
    EP_NOISE
  } episode_t;

  logic clk;
  logic rst;

  cia_req_if req_ch ();
  cia_rsp_if rsp_ch ();

  int unsigned errors;
  int unsigned expected_left;
  int unsigned n_checked;
  int unsigned n_granted;
  int unsigned n_empty;
  int unsigned n_completed;
  int unsigned n_released;
  int unsigned n_ignored;

  command_id_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  cia_tag_checker chk (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .errors        (errors),
    .expected_left (expected_left),
    .n_checked     (n_checked),
    .n_granted     (n_granted),
    .n_empty       (n_empty),
    .n_completed   (n_completed),
    .n_released    (n_released),
    .n_ignored     (n_ignored)
  );

  // Ids seen pending or completed in transfers taken from the block
  bit          pending_pool   [CAPACITY];
  bit          completed_pool [CAPACITY];
  bit          req_gaps;
  bit          rsp_gaps;
  int unsigned items_sent;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_gap(input bit enabled);
    return enabled ? $urandom_range(0, 9) : 0;
  endfunction

  // Pick a marked id starting from a random slot; fall back to any id
  function automatic bit pick_id(input bit pool [CAPACITY],
                                 output logic [ID_W-1:0] pick);
    int unsigned start;
    start = $urandom_range(0, CAPACITY - 1);
    for (int k = 0; k < CAPACITY; k++) begin
      if (pool[(start + k) % CAPACITY]) begin
        pick = ID_W'((start + k) % CAPACITY);
        return 1'b1;
      end
    end
    pick = ID_W'(start);
    return 1'b0;
  endfunction

  // Drive one request at the falling edge and hold it until transfer
  task automatic send_req(input cia_mode_t mode, input logic [ID_W-1:0] id);
    int unsigned gap;
    gap = draw_gap(req_gaps);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.id    <= id;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_complete();
    logic [ID_W-1:0] id;
    if (pick_id(pending_pool, id)) pending_pool[id] = 1'b0;
    send_req(MODE_COMPLETE, id);
  endtask

  task automatic send_release();
    logic [ID_W-1:0] id;
    if (pick_id(completed_pool, id)) completed_pool[id] = 1'b0;
    send_req(MODE_RELEASE, id);
  endtask

  task automatic send_any();
    send_req(cia_mode_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, CAPACITY - 1)));
  endtask

  // Hold the request side until every expected result has arrived
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  task automatic issue_item(input episode_t kind);
    int unsigned     roll;
    logic [ID_W-1:0] id;
    roll = $urandom_range(0, 99);
    id   = ID_W'($urandom_range(0, CAPACITY - 1));
    case (kind)
      EP_FILL: begin
        if (roll < 75)      send_req(MODE_ALLOC, id);
        else if (roll < 85) send_complete();
        else if (roll < 95) send_req(MODE_QUERY, id);
        else                send_any();
      end
      EP_DRAIN: begin
        if (roll < 45)      send_complete();
        else if (roll < 90) send_release();
        else if (roll < 95) send_req(MODE_QUERY, id);
        else                send_req(MODE_ALLOC, id);
      end
      EP_MIXED: begin
        if (roll < 30)      send_req(MODE_ALLOC, id);
        else if (roll < 60) send_complete();
        else if (roll < 90) send_release();
        else                send_any();
      end
      default: send_any();
    endcase
  endtask

  // Response side: stall a random number of cycles after each transfer
  initial begin
    int unsigned hold;
    rsp_ch.ready = 1'b0;
    hold         = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        hold = draw_gap(rsp_gaps);
        if (rsp_ch.applied) begin
          case (cia_status_t'(rsp_ch.id_status))
            ST_PENDING: pending_pool[rsp_ch.result_id] = 1'b1;
            ST_COMPLETED: begin
              pending_pool[rsp_ch.result_id]   = 1'b0;
              completed_pool[rsp_ch.result_id] = 1'b1;
            end
            default: completed_pool[rsp_ch.result_id] = 1'b0;
          endcase
        end
      end
      @(negedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold != 0) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_left);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    episode_t    kind;
    int unsigned len;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_QUERY;
    req_ch.id    = '0;
    req_gaps     = 1'b1;
    rsp_gaps     = 1'b1;
    items_sent   = 0;
    for (int k = 0; k < CAPACITY; k++) begin
      pending_pool[k]   = 1'b0;
      completed_pool[k] = 1'b0;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed walk over every transition and the ignored cases
    send_req(MODE_QUERY,    '0);
    send_req(MODE_QUERY,    '1);
    send_req(MODE_COMPLETE, 6'd5);   // free id: ignored
    send_req(MODE_RELEASE,  6'd5);   // free id: ignored
    send_req(MODE_ALLOC,    '1);     // id field has no effect
    send_req(MODE_ALLOC,    '0);
    send_req(MODE_RELEASE,  6'd0);   // pending id: ignored
    send_req(MODE_COMPLETE, 6'd0);
    send_req(MODE_COMPLETE, 6'd0);   // already completed: ignored
    send_req(MODE_QUERY,    6'd0);
    send_req(MODE_ALLOC,    6'd42);
    send_req(MODE_RELEASE,  6'd0);   // back to free, pushed at the tail
    send_req(MODE_RELEASE,  6'd0);   // already free: ignored
    send_req(MODE_COMPLETE, 6'd1);
    send_req(MODE_COMPLETE, 6'd2);
    send_req(MODE_RELEASE,  6'd2);
    send_req(MODE_RELEASE,  6'd1);
    send_req(MODE_QUERY,    6'd1);
    send_req(MODE_COMPLETE, '1);     // free id: ignored
    send_req(MODE_QUERY,    '1);
    wait_idle();

    // Allocate past the end of the free ring, no gaps on either side
    req_gaps = 1'b0;
    rsp_gaps = 1'b0;
    repeat (CAPACITY + 3) send_req(MODE_ALLOC, ID_W'($urandom_range(0, CAPACITY - 1)));
    wait_idle();

    // Random episodes
    while (items_sent < TOTAL_ITEMS) begin
      kind     = episode_t'($urandom_range(0, 3));
      len      = $urandom_range(20, 120);
      req_gaps = ($urandom_range(0, 3) != 0);
      rsp_gaps = ($urandom_range(0, 3) != 0);
      repeat (len) issue_item(kind);
      if ($urandom_range(0, 4) == 0) wait_idle();
    end

    req_ch.valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests, checked %0d results: %0d ids granted, %0d allocations on an empty ring,",
             items_sent, n_checked, n_granted, n_empty);
    $display("%0d completions, %0d releases, %0d transitions ignored, %0d failures",
             n_completed, n_released, n_ignored, errors);
    if (errors == 0 && expected_left == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
